### sv/mbs_pkg.sv
// shared types, constants and helper functions for the maze backtracker step block
package mbs_pkg;

    // default cell grid capacity
    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF = 32;

    // field widths
    localparam int FIELD_W = 7;
    localparam int RAND_W  = 15;

    // configuration register indexes
    localparam logic CFG_FIELD_WIDTH  = 1'b0;
    localparam logic CFG_FIELD_HEIGHT = 1'b1;

    // register reset and small field limit
    localparam logic [FIELD_W-1:0] FIELD_RESET = 7'd9;
    localparam logic [FIELD_W-1:0] MIN_FIELD   = 7'd5;

    // neighbour directions in probe order
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef struct packed {
        logic              start_req;
        logic [RAND_W-1:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] wall_x;
        logic [FIELD_W-1:0] wall_y;
        logic               carved;
        logic               done_res;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic clear;
        logic start_fin;
        logic probe;
        logic capture;
        t_dir dir;
        logic decide;
        logic pop_load;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic start;
        logic finished;
        logic has_cand;
        logic stack_nonempty;
        logic clear_last;
        logic out_free;
    } t_status;

    // value mod 3 by summing base-4 digits
    function automatic logic [1:0] mbs_mod3(input logic [RAND_W-1:0] v);
        logic [15:0] e;
        logic [4:0]  s;
        logic [2:0]  t;
        e = {1'b0, v};
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(e[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    // random value modulo candidate count (1 to 4)
    function automatic logic [1:0] mbs_pick(input logic [RAND_W-1:0] v, input logic [2:0] cnt);
        logic [1:0] p;
        case (cnt)
            3'd2:    p = {1'b0, v[0]};
            3'd3:    p = mbs_mod3(v);
            3'd4:    p = v[1:0];
            default: p = 2'd0;
        endcase
        return p;
    endfunction

    // direction of the pick-th set candidate bit
    function automatic t_dir mbs_sel_dir(input logic [3:0] cand, input logic [1:0] pick);
        logic [1:0] seen;
        t_dir       dir;
        seen = '0;
        dir  = DIR_UP;
        for (int d = 0; d < 4; d++) begin
            if (cand[d]) begin
                if (seen == pick) begin
                    dir = t_dir'(d[1:0]);
                end
                seen = seen + 1'b1;
            end
        end
        return dir;
    endfunction

endpackage

### sv/mbs_ram.sv
// generic single write port, single read port ram with registered read
module mbs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mbs_ctrl.sv
// sequencing state machine of the maze backtracker step block
module mbs_ctrl
    import mbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_START_FIN,
        S_PROBE,
        S_CAPTURE,
        S_DECIDE,
        S_POP,
        S_RESULT
    } t_state;

    t_state     r_state;
    logic [1:0] r_dir;
    logic       w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = w_accept;
        o_cmd.clear     = (r_state == S_CLEAR);
        o_cmd.start_fin = (r_state == S_START_FIN);
        o_cmd.probe     = (r_state == S_PROBE);
        o_cmd.dir       = t_dir'(r_dir);
        o_cmd.capture   = ((r_state == S_PROBE) && (r_dir != 2'd0)) || (r_state == S_CAPTURE);
        o_cmd.decide    = (r_state == S_DECIDE);
        o_cmd.pop_load  = (r_state == S_POP);
        o_cmd.emit      = (r_state == S_RESULT) && i_status.out_free;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dir   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_dir <= '0;
                    if (i_status.start) begin
                        r_state <= S_CLEAR;
                    end else if (i_status.finished) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_PROBE;
                    end
                end
                S_CLEAR: begin
                    if (i_status.clear_last) begin
                        r_state <= S_START_FIN;
                    end
                end
                S_START_FIN: begin
                    r_state <= S_RESULT;
                end
                S_PROBE: begin
                    r_dir <= r_dir + 1'b1;
                    if (r_dir == 2'd3) begin
                        r_state <= S_CAPTURE;
                    end
                end
                S_CAPTURE: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!i_status.has_cand && i_status.stack_nonempty) begin
                        r_state <= S_POP;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_POP: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted item always starts dispatch
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_DISPATCH)
        else $error("accepted item did not enter dispatch");

    // the four probes finish before a decision
    a_probe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECIDE |-> $past(r_state) == S_CAPTURE)
        else $error("decision without completed probes");

endmodule

### sv/mbs_dp.sv
// datapath of the maze backtracker step block: maze state, memories, result register
module mbs_dp
    import mbs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_data,
    input  t_in_item           i_in_data,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data
);

    localparam int CELL_CAP = MAX_COLS * MAX_ROWS;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int IDX_W    = $clog2(CELL_CAP);
    localparam int DEPTH_W  = $clog2(CELL_CAP + 1);
    localparam int NCOL_W   = $clog2(MAX_COLS + 1);
    localparam int NROW_W   = $clog2(MAX_ROWS + 1);
    localparam int POS_W    = ROW_W + COL_W;

    // control state
    logic [FIELD_W-1:0] r_field_width;
    logic [FIELD_W-1:0] r_field_height;
    logic [COL_W-1:0]   r_cur_x;
    logic [ROW_W-1:0]   r_cur_y;
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] r_unvisited;
    logic               r_finished;
    logic               r_out_valid;

    // payload state
    logic               r_start;
    logic [RAND_W-1:0]  r_rand;
    logic [3:0]         r_cand;
    t_dir               r_pend_dir;
    logic               r_pend_inb;
    logic [IDX_W-1:0]   r_clr_addr;
    logic [FIELD_W-1:0] r_res_wall_x;
    logic [FIELD_W-1:0] r_res_wall_y;
    logic               r_res_carved;
    t_out_item          r_out_data;

    // grid size from live registers
    logic [FIELD_W-1:0] w_half_w;
    logic [FIELD_W-1:0] w_half_h;
    logic [NCOL_W-1:0]  w_ncols;
    logic [NROW_W-1:0]  w_nrows;
    logic               w_small;
    logic [DEPTH_W-1:0] w_start_unv;

    assign w_half_w = (r_field_width == '0) ? '0 : ((r_field_width - 1'b1) >> 1);
    assign w_half_h = (r_field_height == '0) ? '0 : ((r_field_height - 1'b1) >> 1);
    assign w_ncols  = (w_half_w > FIELD_W'(MAX_COLS)) ? NCOL_W'(MAX_COLS) : NCOL_W'(w_half_w);
    assign w_nrows  = (w_half_h > FIELD_W'(MAX_ROWS)) ? NROW_W'(MAX_ROWS) : NROW_W'(w_half_h);
    assign w_small  = (r_field_width < MIN_FIELD) || (r_field_height < MIN_FIELD);
    assign w_start_unv = DEPTH_W'(DEPTH_W'(w_ncols) * DEPTH_W'(w_nrows) - 1'b1);

    // candidate count and pick
    logic [2:0] w_cnt;
    logic [1:0] w_pick;
    t_dir       w_pick_dir;
    logic       w_has_cand;

    assign w_cnt      = 3'(r_cand[0]) + 3'(r_cand[1]) + 3'(r_cand[2]) + 3'(r_cand[3]);
    assign w_pick     = mbs_pick(r_rand, w_cnt);
    assign w_pick_dir = mbs_sel_dir(r_cand, w_pick);
    assign w_has_cand = (w_cnt != 3'd0);

    // neighbour of the current cell in the selected direction
    t_dir             w_sel_dir;
    logic [COL_W-1:0] w_nb_x;
    logic [ROW_W-1:0] w_nb_y;
    logic             w_nb_inb;
    logic [IDX_W-1:0] w_nb_idx;
    logic [7:0]       w_wx;
    logic [7:0]       w_wy;
    logic             w_x_in;
    logic             w_y_in;

    assign w_sel_dir = i_cmd.decide ? w_pick_dir : i_cmd.dir;

    // current column and row inside the live grid (may lie outside after a shrink)
    assign w_x_in = (NCOL_W+1)'(r_cur_x) < (NCOL_W+1)'(w_ncols);
    assign w_y_in = (NROW_W+1)'(r_cur_y) < (NROW_W+1)'(w_nrows);

    always_comb begin
        w_nb_x = r_cur_x;
        w_nb_y = r_cur_y;
        w_wx   = 8'({r_cur_x, 1'b1});
        w_wy   = 8'({r_cur_y, 1'b1});
        case (w_sel_dir)
            DIR_UP: begin
                w_nb_inb = (r_cur_y != '0)
                           && ((NROW_W+1)'(r_cur_y) <= (NROW_W+1)'(w_nrows)) && w_x_in;
                w_nb_y   = r_cur_y - 1'b1;
                w_wy     = 8'({r_cur_y, 1'b1}) - 8'd1;
            end
            DIR_DOWN: begin
                w_nb_inb = (((NROW_W+1)'(r_cur_y) + 1'b1) < (NROW_W+1)'(w_nrows)) && w_x_in;
                w_nb_y   = r_cur_y + 1'b1;
                w_wy     = 8'({r_cur_y, 1'b1}) + 8'd1;
            end
            DIR_LEFT: begin
                w_nb_inb = (r_cur_x != '0)
                           && ((NCOL_W+1)'(r_cur_x) <= (NCOL_W+1)'(w_ncols)) && w_y_in;
                w_nb_x   = r_cur_x - 1'b1;
                w_wx     = 8'({r_cur_x, 1'b1}) - 8'd1;
            end
            DIR_RIGHT: begin
                w_nb_inb = (((NCOL_W+1)'(r_cur_x) + 1'b1) < (NCOL_W+1)'(w_ncols)) && w_y_in;
                w_nb_x   = r_cur_x + 1'b1;
                w_wx     = 8'({r_cur_x, 1'b1}) + 8'd1;
            end
            default: begin
                w_nb_inb = 1'b0;
            end
        endcase
    end

    assign w_nb_idx = IDX_W'(w_nb_y) * IDX_W'(MAX_COLS) + IDX_W'(w_nb_x);

    // visited map port control
    logic             w_vis_we;
    logic [IDX_W-1:0] w_vis_waddr;
    logic             w_vis_wdata;
    logic             w_vis_rdata;
    logic             w_carve;

    assign w_carve     = i_cmd.decide && w_has_cand;
    assign w_vis_we    = i_cmd.clear || (i_cmd.start_fin && !w_small) || w_carve;
    assign w_vis_waddr = i_cmd.clear ? r_clr_addr : (i_cmd.start_fin ? '0 : w_nb_idx);
    assign w_vis_wdata = !i_cmd.clear;

    mbs_ram #(
        .WIDTH (1),
        .DEPTH (CELL_CAP)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_raddr (w_nb_idx),
        .o_rdata (w_vis_rdata)
    );

    // path stack port control
    logic             w_stk_we;
    logic [POS_W-1:0] w_stk_rdata;

    assign w_stk_we = w_carve && (r_depth < DEPTH_W'(CELL_CAP));

    mbs_ram #(
        .WIDTH (POS_W),
        .DEPTH (CELL_CAP)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (IDX_W'(r_depth)),
        .i_wdata ({r_cur_y, r_cur_x}),
        .i_raddr (IDX_W'(r_depth - 1'b1)),
        .o_rdata (w_stk_rdata)
    );

    // unvisited count after a carve
    logic [DEPTH_W-1:0] w_unv_dec;
    assign w_unv_dec = (r_unvisited != '0) ? (r_unvisited - 1'b1) : r_unvisited;

    // maze control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= FIELD_RESET;
            r_field_height <= FIELD_RESET;
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_depth        <= '0;
            r_unvisited    <= '0;
            r_finished     <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIELD_WIDTH:  r_field_width  <= i_cfg_data;
                    CFG_FIELD_HEIGHT: r_field_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start_fin) begin
                r_cur_x <= '0;
                r_cur_y <= '0;
                r_depth <= '0;
                if (w_small) begin
                    r_unvisited <= '0;
                    r_finished  <= 1'b1;
                end else begin
                    r_unvisited <= w_start_unv;
                    r_finished  <= (w_start_unv == '0);
                end
            end
            if (i_cmd.decide) begin
                if (w_has_cand) begin
                    r_cur_x     <= w_nb_x;
                    r_cur_y     <= w_nb_y;
                    r_unvisited <= w_unv_dec;
                    if (w_stk_we) begin
                        r_depth <= r_depth + 1'b1;
                    end
                    if (w_unv_dec == '0) begin
                        r_finished <= 1'b1;
                    end
                end else if (r_depth != '0) begin
                    r_depth <= r_depth - 1'b1;
                end else begin
                    r_finished <= 1'b1;
                end
            end
            if (i_cmd.pop_load) begin
                {r_cur_y, r_cur_x} <= w_stk_rdata;
            end
            // output register: load on emit, drop on transfer
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload, probe results and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_start      <= i_in_data.start_req;
            r_rand       <= i_in_data.random_value;
            r_cand       <= '0;
            r_clr_addr   <= '0;
            r_res_wall_x <= '0;
            r_res_wall_y <= '0;
            r_res_carved <= 1'b0;
        end
        if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
        if (i_cmd.probe) begin
            r_pend_dir <= i_cmd.dir;
            r_pend_inb <= w_nb_inb;
        end
        if (i_cmd.capture && r_pend_inb && !w_vis_rdata) begin
            r_cand[r_pend_dir] <= 1'b1;
        end
        if (w_carve) begin
            r_res_wall_x <= w_wx[FIELD_W-1:0];
            r_res_wall_y <= w_wy[FIELD_W-1:0];
            r_res_carved <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_data.wall_x   <= r_res_wall_x;
            r_out_data.wall_y   <= r_res_wall_y;
            r_out_data.carved   <= r_res_carved;
            r_out_data.done_res <= r_finished;
        end
    end

    // status to the controller
    always_comb begin
        o_status                = '0;
        o_status.start          = r_start;
        o_status.finished       = r_finished;
        o_status.has_cand       = w_has_cand;
        o_status.stack_nonempty = (r_depth != '0);
        o_status.clear_last     = (r_clr_addr == IDX_W'(CELL_CAP - 1));
        o_status.out_free       = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // an opened wall never lies on the border
    a_wall_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.carved |-> o_out_data.wall_x != '0 && o_out_data.wall_y != '0)
        else $error("carved wall on border");

    // carving only happens while the maze is unfinished
    a_carve_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_carve |-> !r_finished)
        else $error("carve after finish");

    // a push grows the stack by one
    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stk_we |=> r_depth == $past(r_depth) + 1'b1)
        else $error("stack depth not advanced on push");

    // stack depth stays within capacity
    a_depth_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(CELL_CAP))
        else $error("stack depth beyond capacity");

endmodule

### sv/maze_backtracker_step.sv
// top level of the maze backtracker step block
//
// Each accepted item runs one step of a randomized depth-first maze carver and
// gives exactly one result. In a step item the four neighbour visited bits are
// read one after another through the single read port of the visited map,
// then the choice, the stack push or pop and the result load follow. A step
// once the maze is done goes straight to the result. A start item clears the
// whole visited map one entry per cycle. Only one item is in work at a time;
// the result register lets the next item enter while the previous result
// waits to be taken. Field width and height are to be written only while the
// block is idle; the block itself does not enforce this.
module maze_backtracker_step
    import mbs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // step sequencer
    mbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // maze state and memories
    mbs_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
